[rtl/sphere_overlap_admit_table_core_defines.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the sphere overlap admit table
// Concurrent assertion wrappers, compiled out when ASSERT_OFF is defined.
// ----------------------------------------------------------------------------
`ifndef SPHERE_OVERLAP_ADMIT_TABLE_CORE_DEFINES_SVH
`define SPHERE_OVERLAP_ADMIT_TABLE_CORE_DEFINES_SVH

`ifndef ASSERT_OFF
`define SOAT_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define SOAT_ASSERT_RST(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define SOAT_ASSERT(lbl, clk, rst_n, prop, msg)
`define SOAT_ASSERT_RST(lbl, clk, prop, msg)
`endif

`endif

[rtl/soat_pkg.sv]
// ----------------------------------------------------------------------------
// Sphere overlap admit table package
// Field widths, request and response types, and the bus between cells.
// ----------------------------------------------------------------------------
package soat_pkg;

    localparam int unsigned CAPACITY_DEF = 512;
    localparam int unsigned COORD_W      = 16;
    localparam int unsigned RADIUS_W     = 12;
    localparam int unsigned COUNT_W      = 10;
    localparam int unsigned DIFF_W       = COORD_W + 1;
    localparam int unsigned SUM_W        = 2 * DIFF_W;
    localparam int unsigned RSUM_W       = RADIUS_W + 1;
    localparam int unsigned RSQ_W        = 2 * RSUM_W;
    localparam int unsigned AXES         = 3;

    localparam logic OP_TEST  = 1'b0;
    localparam logic OP_CLEAR = 1'b1;

    typedef struct packed {
        logic                       operation;
        logic signed [COORD_W-1:0]  center_x;
        logic signed [COORD_W-1:0]  center_y;
        logic signed [COORD_W-1:0]  center_z;
        logic        [RADIUS_W-1:0] sphere_radius;
    } t_in_req;

    typedef struct packed {
        logic               accepted;
        logic               table_full;
        logic [COUNT_W-1:0] stored_count;
    } t_out_rsp;

    typedef struct packed {
        logic signed [COORD_W-1:0]  x;
        logic signed [COORD_W-1:0]  y;
        logic signed [COORD_W-1:0]  z;
        logic        [RADIUS_W-1:0] r;
    } t_entry;

    typedef struct packed {
        logic             vld;
        logic [SUM_W-1:0] sum;
        t_entry           entry;
        t_entry           cand;
    } t_cell_bus;

endpackage

[rtl/sphere_overlap_admit_table_core.sv]
// ----------------------------------------------------------------------------
// Sphere overlap admit table
// A request either clears the table or tests a candidate sphere against every
// stored sphere and appends it when it overlaps none and a free entry exists.
// Requests arrive on i_in_valid / o_in_stall with payload i_in_req; one
// response per request leaves on o_out_valid / i_out_stall as o_out_rsp.
// A test walks the store one entry per cycle through a chain of three
// distance cells, then drains the chain in S_DRAIN and registers its response
// from S_DONE; a clear or a test on an empty table goes straight to S_DONE.
// The store's single read port sets the walk rate: one request is in flight
// at a time and the next one is taken in the cycle after its response is registered.
// The response register holds while i_out_stall is high; a new request is
// still taken then, and its response waits until the register frees.
// Reset empties the table and drops any pending response; the store itself
// is not cleared, as entries at or above the fill count are never read.
// ----------------------------------------------------------------------------
`include "sphere_overlap_admit_table_core_defines.svh"

module sphere_overlap_admit_table_core import soat_pkg::*; #(
    parameter int unsigned CAPACITY = CAPACITY_DEF
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_stall,
    input  t_in_req  i_in_req,
    output logic     o_out_valid,
    input  logic     i_out_stall,
    output t_out_rsp o_out_rsp
);

    localparam int unsigned AW    = $clog2(CAPACITY);
    localparam int unsigned FCW   = $clog2(CAPACITY + 1);
    localparam int unsigned EXT_W = FCW + COUNT_W;

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_WALK  = 4'b0010,
        S_DRAIN = 4'b0100,
        S_DONE  = 4'b1000
    } t_state;

    t_state            r_state, n_state;
    logic [FCW-1:0]    r_fill, n_fill;
    logic [FCW-1:0]    r_issue, n_issue;
    logic              r_clear, n_clear;
    logic              r_hit, n_hit;
    t_entry            r_cand, n_cand;
    logic              r_out_vld, n_out_vld;
    t_out_rsp          r_out_rsp, n_out_rsp;

    logic              mem_we;
    logic              mem_re;
    t_entry            rd_data;
    logic              rd_vld;
    t_cell_bus         cell_bus [AXES+1];
    logic [RSUM_W-1:0] rsum;
    logic [RSQ_W-1:0]  rsq;
    logic              hit;
    logic              pipe_busy;
    logic [FCW-1:0]    fill_inc;
    logic [EXT_W-1:0]  ext_fill;
    logic [EXT_W-1:0]  ext_inc;

    soat_store #(
        .CAPACITY (CAPACITY)
    ) u_store (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr_en   (mem_we),
        .i_wr_addr (r_fill[AW-1:0]),
        .i_wr_data (r_cand),
        .i_rd_en   (mem_re),
        .i_rd_addr (r_issue[AW-1:0]),
        .o_rd_data (rd_data),
        .o_rd_vld  (rd_vld)
    );

    assign cell_bus[0] = '{vld: rd_vld, sum: '0, entry: rd_data, cand: r_cand};

    for (genvar g = 0; g < AXES; g++) begin : g_cell
        soat_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_bus   (cell_bus[g]),
            .o_bus   (cell_bus[g+1])
        );
    end

    always_comb begin
        rsum = RSUM_W'(cell_bus[AXES].entry.r) + RSUM_W'(cell_bus[AXES].cand.r);
        rsq  = rsum * rsum;
        hit  = cell_bus[AXES].vld && (cell_bus[AXES].sum < SUM_W'(rsq));
        pipe_busy = rd_vld;
        for (int k = 1; k <= AXES; k++) begin
            pipe_busy = pipe_busy | cell_bus[k].vld;
        end
        fill_inc = FCW'(r_fill + 1'b1);
        ext_fill = EXT_W'(r_fill);
        ext_inc  = EXT_W'(fill_inc);
    end

    always_comb begin
        n_state   = r_state;
        n_fill    = r_fill;
        n_issue   = r_issue;
        n_clear   = r_clear;
        n_hit     = r_hit | hit;
        n_cand    = r_cand;
        n_out_vld = r_out_vld && i_out_stall;
        n_out_rsp = r_out_rsp;
        mem_we    = 1'b0;
        mem_re    = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_cand  = '{x: i_in_req.center_x, y: i_in_req.center_y,
                                z: i_in_req.center_z, r: i_in_req.sphere_radius};
                    n_clear = (i_in_req.operation == OP_CLEAR);
                    n_hit   = 1'b0;
                    n_issue = '0;
                    if (i_in_req.operation == OP_CLEAR || r_fill == '0) begin
                        n_state = S_DONE;
                    end else begin
                        n_state = S_WALK;
                    end
                end
            end
            S_WALK: begin
                mem_re  = 1'b1;
                n_issue = FCW'(r_issue + 1'b1);
                if (r_issue == FCW'(r_fill - 1'b1)) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                if (!pipe_busy) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (!r_out_vld || !i_out_stall) begin
                    n_out_vld = 1'b1;
                    n_state   = S_IDLE;
                    if (r_clear) begin
                        n_fill    = '0;
                        n_out_rsp = '{accepted: 1'b0, table_full: 1'b0, stored_count: '0};
                    end else if (r_hit) begin
                        n_out_rsp = '{accepted: 1'b0, table_full: 1'b0,
                                      stored_count: ext_fill[COUNT_W-1:0]};
                    end else if (r_fill == FCW'(CAPACITY)) begin
                        n_out_rsp = '{accepted: 1'b0, table_full: 1'b1,
                                      stored_count: ext_fill[COUNT_W-1:0]};
                    end else begin
                        mem_we    = 1'b1;
                        n_fill    = fill_inc;
                        n_out_rsp = '{accepted: 1'b1, table_full: 1'b0,
                                      stored_count: ext_inc[COUNT_W-1:0]};
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_fill    <= '0;
            r_issue   <= '0;
            r_clear   <= 1'b0;
            r_hit     <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_fill    <= n_fill;
            r_issue   <= n_issue;
            r_clear   <= n_clear;
            r_hit     <= n_hit;
            r_out_vld <= n_out_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cand    <= n_cand;
        r_out_rsp <= n_out_rsp;
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_vld;
    assign o_out_rsp   = r_out_rsp;

    `SOAT_ASSERT(a_fill_bound, i_clk, i_rst_n, r_fill <= FCW'(CAPACITY), "Fill count exceeds capacity.")
    `SOAT_ASSERT(a_issue_range, i_clk, i_rst_n, (r_state == S_WALK) |-> (r_issue < r_fill), "Read beyond the filled entries.")
    `SOAT_ASSERT(a_pipe_in_walk, i_clk, i_rst_n, pipe_busy |-> (r_state == S_WALK || r_state == S_DRAIN), "Distance chain busy outside a walk.")
    `SOAT_ASSERT_RST(a_reset_quiet, i_clk, !i_rst_n |=> (!o_out_valid && r_state == S_IDLE), "Block not idle after reset.")

endmodule

[rtl/soat_store.sv]
// ----------------------------------------------------------------------------
// Sphere store
// One write port and one registered read port over the table of spheres.
// ----------------------------------------------------------------------------
module soat_store import soat_pkg::*; #(
    parameter int unsigned CAPACITY = CAPACITY_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_wr_en,
    input  logic [$clog2(CAPACITY)-1:0] i_wr_addr,
    input  t_entry                      i_wr_data,
    input  logic                        i_rd_en,
    input  logic [$clog2(CAPACITY)-1:0] i_rd_addr,
    output t_entry                      o_rd_data,
    output logic                        o_rd_vld
);

    t_entry r_mem [CAPACITY];
    t_entry r_rd_data;
    logic   r_rd_vld;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_vld <= 1'b0;
        end else begin
            r_rd_vld <= i_rd_en;
        end
    end

    assign o_rd_data = r_rd_data;
    assign o_rd_vld  = r_rd_vld;

endmodule

[rtl/soat_cell.sv]
// ----------------------------------------------------------------------------
// Distance cell
// Adds the squared x difference to the running sum and rotates the axes.
// ----------------------------------------------------------------------------
module soat_cell import soat_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_cell_bus i_bus,
    output t_cell_bus o_bus
);

    logic signed [DIFF_W-1:0] diff;
    logic [DIFF_W-1:0]        mag;
    logic [SUM_W-1:0]         prod;
    logic [SUM_W-1:0]         n_sum;
    t_entry                   n_entry;
    t_entry                   n_cand;

    logic                     r_vld;
    logic [SUM_W-1:0]         r_sum;
    t_entry                   r_entry;
    t_entry                   r_cand;

    always_comb begin
        diff    = {i_bus.cand.x[COORD_W-1], i_bus.cand.x}
                - {i_bus.entry.x[COORD_W-1], i_bus.entry.x};
        mag     = diff[DIFF_W-1] ? DIFF_W'(-diff) : DIFF_W'(diff);
        prod    = mag * mag;
        n_sum   = i_bus.sum + prod;
        n_entry = '{x: i_bus.entry.y, y: i_bus.entry.z, z: i_bus.entry.x, r: i_bus.entry.r};
        n_cand  = '{x: i_bus.cand.y, y: i_bus.cand.z, z: i_bus.cand.x, r: i_bus.cand.r};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else begin
            r_vld <= i_bus.vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_sum   <= n_sum;
        r_entry <= n_entry;
        r_cand  <= n_cand;
    end

    assign o_bus = '{vld: r_vld, sum: r_sum, entry: r_entry, cand: r_cand};

endmodule
